/* src/urd_pkg.sv */
// shared widths and pipeline stage types for the unsigned restoring divider
// no dependencies
package urd_pkg;

  localparam int unsigned FieldW = 32;
  localparam int unsigned Width  = 32;
  localparam int unsigned MaxW   = (Width > FieldW) ? Width : FieldW;
  localparam int unsigned WarmW  = $clog2(Width + 1);

  typedef struct packed {
    logic valid;
    logic dbz;
  } ctrl_t;

  typedef struct packed {
    logic [Width-1:0] num;
    logic [Width-1:0] den;
    logic [Width-1:0] part;
    logic [Width-1:0] quo;
  } data_t;

endpackage

/* src/urd_stage.sv */
// one restoring division step with its pipeline register
// depends on urd_pkg
module urd_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  urd_pkg::ctrl_t ctrl_i,
  input  urd_pkg::data_t data_i,
  output urd_pkg::ctrl_t ctrl_o,
  output urd_pkg::data_t data_o
);

  logic                       top;
  logic [urd_pkg::Width-1:0]  shifted;
  logic [urd_pkg::Width:0]    trial;
  urd_pkg::ctrl_t             ctrl_q;
  urd_pkg::data_t             data_d, data_q;

  assign top     = data_i.part[urd_pkg::Width-1];
  assign shifted = {data_i.part[urd_pkg::Width-2:0], data_i.num[urd_pkg::Width-1]};
  // borrow out of the wide subtract means the trial went negative
  assign trial   = {top, shifted} - {1'b0, data_i.den};

  always_comb begin
    data_d.num = {data_i.num[urd_pkg::Width-2:0], 1'b0};
    data_d.den = data_i.den;
    if (!trial[urd_pkg::Width]) begin
      data_d.part = trial[urd_pkg::Width-1:0];
      data_d.quo  = {data_i.quo[urd_pkg::Width-2:0], 1'b1};
    end else begin
      data_d.part = shifted;
      data_d.quo  = {data_i.quo[urd_pkg::Width-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.valid) begin
      data_q <= data_d;
    end
  end

  assign ctrl_o = ctrl_q;
  assign data_o = data_q;

endmodule

/* src/unsigned_restoring_divider.sv */
// unsigned restoring divider, one pipeline stage per quotient bit
// depends on urd_pkg and urd_stage
//
// usage:
//   drive dividend_i and divisor_i with start_i high; the transfer happens at
//   the rising edge where start_i is high and busy_o is low. busy_o is never
//   raised, so a new operand pair can be transferred in every cycle.
//   the result appears on quotient_o, remainder_o and div_by_zero_o for
//   exactly one cycle with done_o high, after the operands have passed
//   through the chain of Width registered step stages.
//   throughput is one division per cycle; results leave in transfer order.
//   a zero divisor gives quotient 0, remainder 0 and div_by_zero_o high.
//   the receiver cannot hold results off, so nothing ever stalls.
//   reset (rst_ni low, asynchronous) clears every stage valid bit; items in
//   flight are dropped and done_o stays low until new transfers arrive.
module unsigned_restoring_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [urd_pkg::FieldW-1:0] dividend_i,
  input  logic [urd_pkg::FieldW-1:0] divisor_i,
  output logic                       done_o,
  output logic [urd_pkg::FieldW-1:0] quotient_o,
  output logic [urd_pkg::FieldW-1:0] remainder_o,
  output logic                       div_by_zero_o
);

  logic [urd_pkg::MaxW-1:0]  dividend_ext, divisor_ext, quo_ext, rem_ext;
  urd_pkg::ctrl_t            ctrl [urd_pkg::Width+1];
  urd_pkg::data_t            data [urd_pkg::Width+1];
  urd_pkg::ctrl_t            last_ctrl;
  urd_pkg::data_t            last_data;

  assign busy_o = 1'b0;

  // operand bits above Width are dropped
  assign dividend_ext = urd_pkg::MaxW'(dividend_i);
  assign divisor_ext  = urd_pkg::MaxW'(divisor_i);

  always_comb begin
    ctrl[0].valid = start_i;
    ctrl[0].dbz   = (divisor_ext[urd_pkg::Width-1:0] == '0);
    data[0].num   = dividend_ext[urd_pkg::Width-1:0];
    data[0].den   = divisor_ext[urd_pkg::Width-1:0];
    data[0].part  = '0;
    data[0].quo   = '0;
  end

  for (genvar i = 0; i < urd_pkg::Width; i++) begin : g_stage
    urd_stage u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl[i]),
      .data_i (data[i]),
      .ctrl_o (ctrl[i+1]),
      .data_o (data[i+1])
    );
  end

  assign last_ctrl = ctrl[urd_pkg::Width];
  assign last_data = data[urd_pkg::Width];

  assign quo_ext = urd_pkg::MaxW'(last_data.quo);
  assign rem_ext = urd_pkg::MaxW'(last_data.part);

  assign done_o        = last_ctrl.valid;
  assign div_by_zero_o = last_ctrl.dbz;
  assign quotient_o    = last_ctrl.dbz ? '0 : quo_ext[urd_pkg::FieldW-1:0];
  assign remainder_o   = last_ctrl.dbz ? '0 : rem_ext[urd_pkg::FieldW-1:0];

endmodule

/* src/urd_checker.sv */
// port-level checks for the unsigned restoring divider, bound to the top level
// depends on urd_pkg and unsigned_restoring_divider
module urd_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start_i,
  input logic                       busy_o,
  input logic [urd_pkg::FieldW-1:0] divisor_i,
  input logic                       done_o,
  input logic [urd_pkg::FieldW-1:0] quotient_o,
  input logic [urd_pkg::FieldW-1:0] remainder_o,
  input logic                       div_by_zero_o
);

  logic [urd_pkg::WarmW-1:0] warm_q;
  logic                      warm;
  logic                      full_w;

  // counts cycles since reset so history checks skip the reset window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warm_q <= '0;
    end else if (!warm) begin
      warm_q <= warm_q + 1'b1;
    end
  end

  assign warm   = (warm_q == urd_pkg::WarmW'(urd_pkg::Width));
  assign full_w = (urd_pkg::Width >= urd_pkg::FieldW);

  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("busy raised");

  a_dbz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && div_by_zero_o |-> quotient_o == '0 && remainder_o == '0)
    else $error("nonzero result on division by zero");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    warm |-> done_o == $past(start_i && !busy_o, urd_pkg::Width))
    else $error("result strobe does not match transfer");

  a_dbz_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    warm && done_o && full_w |->
      div_by_zero_o == ($past(divisor_i, urd_pkg::Width) == '0))
    else $error("zero divisor flag wrong");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    warm && done_o && full_w && !div_by_zero_o |->
      remainder_o < $past(divisor_i, urd_pkg::Width))
    else $error("remainder not below divisor");

endmodule

bind unsigned_restoring_divider urd_checker u_urd_checker (.*);

/* dv/unsigned_restoring_divider_tb.sv */
// self-checking testbench for the unsigned restoring divider, directed and random operands
// a bit-level restoring division predicts every result; depends on urd_pkg and the divider rtl
`timescale 1ns / 100ps

module unsigned_restoring_divider_tb;

  typedef logic [urd_pkg::FieldW-1:0] word_t;
  typedef logic [urd_pkg::Width-1:0]  part_t;

  typedef struct {
    word_t       dividend;
    word_t       divisor;
    int unsigned idle_pct;
  } div_req_t;

  typedef struct {
    word_t dividend;
    word_t divisor;
    word_t quotient;
    word_t remainder;
    logic  dbz;
  } div_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  word_t       dividend_i = '0;
  word_t       divisor_i = '0;
  logic        busy_o;
  logic        done_o;
  word_t       quotient_o;
  word_t       remainder_o;
  logic        div_by_zero_o;

  div_req_t    pending_divs[$];
  div_res_t    expected_results[$];
  div_req_t    next_div;
  div_res_t    want;
  int unsigned n_queued = 0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_dbz = 0;
  int unsigned n_errors = 0;

  unsigned_restoring_divider dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .dividend_i    (dividend_i),
    .divisor_i     (divisor_i),
    .done_o        (done_o),
    .quotient_o    (quotient_o),
    .remainder_o   (remainder_o),
    .div_by_zero_o (div_by_zero_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic div_res_t restoring_divide(input word_t dividend, input word_t divisor);
    part_t                   num;
    part_t                   den;
    part_t                   part;
    part_t                   quo;
    logic [urd_pkg::Width:0] shifted;
    logic [urd_pkg::Width:0] den_ext;
    div_res_t                res;
    num = part_t'(dividend);
    den = part_t'(divisor);
    part = '0;
    quo = '0;
    res.dividend = dividend;
    res.divisor = divisor;
    res.dbz = (den == '0);
    res.quotient = '0;
    res.remainder = '0;
    if (res.dbz) return res;
    den_ext = {1'b0, den};
    for (int k = urd_pkg::Width - 1; k >= 0; k--) begin
      shifted = {part, num[k]};
      quo = quo << 1;
      if (shifted >= den_ext) begin
        shifted = shifted - den_ext;
        quo[0] = 1'b1;
      end
      part = shifted[urd_pkg::Width-1:0];
    end
    res.quotient = word_t'(quo);
    res.remainder = word_t'(part);
    return res;
  endfunction

  function automatic word_t rand_operand();
    word_t v;
    case ($urandom_range(0, 5))
      0, 1: v = word_t'($urandom);
      2: v = word_t'($urandom) >> $urandom_range(0, urd_pkg::FieldW - 1);
      3: v = word_t'($urandom_range(0, 15));
      4: v = '1 - word_t'($urandom_range(0, 15));
      default: v = (word_t'(1) << $urandom_range(0, urd_pkg::FieldW - 1))
                   - word_t'($urandom_range(0, 1));
    endcase
    return v;
  endfunction

  task automatic queue_div(input word_t dividend, input word_t divisor,
                           input int unsigned idle_pct);
    div_req_t r;
    r.dividend = dividend;
    r.divisor = divisor;
    r.idle_pct = idle_pct;
    pending_divs.push_back(r);
    n_queued++;
  endtask

  // driver: one transfer per edge where start_i is high and busy_o low
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        expected_results.push_back(restoring_divide(dividend_i, divisor_i));
        n_sent++;
      end
      if (start_i && busy_o) begin
        start_i <= 1'b1;
      end else if (pending_divs.size() != 0 &&
                   $urandom_range(0, 99) >= pending_divs[0].idle_pct) begin
        next_div = pending_divs.pop_front();
        start_i <= 1'b1;
        dividend_i <= next_div.dividend;
        divisor_i <= next_div.divisor;
      end else begin
        start_i <= 1'b0;
        dividend_i <= word_t'($urandom);
        divisor_i <= word_t'($urandom);
      end
    end
  end

  // monitor: results are strobed for one cycle and cannot be held off
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        if (expected_results.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected result, expected none, got q=%h r=%h z=%b",
                   $time, quotient_o, remainder_o, div_by_zero_o);
        end else begin
          want = expected_results.pop_front();
          n_checked++;
          if (want.dbz) n_dbz++;
          if (quotient_o !== want.quotient || remainder_o !== want.remainder ||
              div_by_zero_o !== want.dbz) begin
            n_errors++;
            $display("%0t: mismatch for %h / %h, expected q=%h r=%h z=%b, got q=%h r=%h z=%b",
                     $time, want.dividend, want.divisor, want.quotient, want.remainder,
                     want.dbz, quotient_o, remainder_o, div_by_zero_o);
          end
        end
      end else if (done_o !== 1'b0) begin
        n_errors++;
        $display("%0t: done_o unknown, expected 0 or 1, got %b", $time, done_o);
      end
    end
  end

  initial begin
    word_t       a;
    word_t       b;
    word_t       top_bit;
    int unsigned idle_by_phase[3];
    idle_by_phase[0] = 0;
    idle_by_phase[1] = 60;
    idle_by_phase[2] = 33;
    top_bit = word_t'(1) << (urd_pkg::FieldW - 1);

    // edge cases: zero divisor, extremes, top divisor bit set, divisor above dividend
    queue_div('0, '0, 0);
    queue_div('1, '0, 0);
    queue_div(word_t'(12345), '0, 0);
    queue_div('0, word_t'(1), 0);
    queue_div('1, word_t'(1), 0);
    queue_div('1, '1, 0);
    queue_div('1 - word_t'(1), '1, 0);
    queue_div('0, '1, 0);
    queue_div('1, top_bit, 0);
    queue_div(top_bit - word_t'(1), top_bit + word_t'(1), 0);
    queue_div(top_bit, top_bit + word_t'(1), 0);
    queue_div('1, top_bit + word_t'(1), 0);
    queue_div('1, word_t'(2), 0);
    queue_div('1, word_t'(3), 0);
    queue_div(word_t'(7), word_t'(3), 0);
    queue_div(word_t'(1), word_t'(2), 0);
    queue_div(word_t'(100), word_t'(100), 0);
    queue_div(word_t'(99), word_t'(100), 0);
    queue_div(top_bit, top_bit >> 1, 0);
    queue_div('1, word_t'(16), 0);
    queue_div(word_t'(32'hdead_beef), word_t'(32'h0001_0000), 0);
    queue_div(word_t'(32'haaaa_aaaa), word_t'(32'h5555_5555), 0);

    for (int p = 0; p < 3; p++) begin
      for (int i = 0; i < 350; i++) begin
        a = rand_operand();
        b = ($urandom_range(0, 24) == 0) ? '0 : rand_operand();
        queue_div(a, b, idle_by_phase[p]);
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_sent != n_queued || expected_results.size() != 0) @(posedge clk_i);
    repeat (urd_pkg::Width + 8) @(posedge clk_i);

    $display("checked %0d divisions, %0d with a zero divisor", n_checked, n_dbz);
    $display("sender idled at 0, 60 and 33 percent across the random phases");
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #(12 * 200000);
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("FAILURE");
    $finish;
  end

endmodule
